/* sv/itd_pkg.sv */
// Shared constants, types and helpers for the integer to ASCII digits unit.
package itd_pkg;

    // Width of the number that is formatted; bits above it are ignored
    localparam int VALUE_WIDTH = 64;
    // Digit store depth: enough decimal digits for any value up to 64 bits
    localparam int DIGITS      = 20;
    localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
    localparam int IDX_W       = $clog2(DIGITS);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    // Format codes
    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    // Character codes
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_NINE    = 7'h39;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_F = 7'h66;
    localparam logic [6:0] CH_MINUS   = 7'h2D;

    typedef logic [DIGITS-1:0][3:0] t_bcd;

    // Control from the sequencer to the shift unit
    typedef struct packed {
        logic load;
        logic hex;
        logic step;
    } t_dd_ctrl;

    // Digit value to lower-case ASCII
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d >= 4'd10) begin
            c = CH_LOWER_A + 7'(d - 4'd10);
        end else begin
            c = CH_ZERO + 7'(d);
        end
        return c;
    endfunction

endpackage

/* sv/itd_dabble.sv */
// Shared shift-and-add-3 unit holding the digit store, one binary bit per step.
module itd_dabble (
    input  logic                        i_clk,
    input  itd_pkg::t_dd_ctrl           i_ctrl,
    input  logic [itd_pkg::VALUE_WIDTH-1:0] i_mag,
    input  logic [itd_pkg::IDX_W-1:0]   i_idx,
    output logic [3:0]                  o_digit
);
    import itd_pkg::*;

    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    t_bcd                   r_bcd, n_bcd;
    t_bcd                   adj;
    logic [DIGITS*4-1:0]    hex_flat;

    assign hex_flat = {{(DIGITS*4-VALUE_WIDTH){1'b0}}, i_mag};

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    // load, or one shift step; the top digit never exceeds 1, so its bit 3 drops
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctrl.load) begin
            if (i_ctrl.hex) begin
                n_bcd = hex_flat;
            end else begin
                n_bcd = '0;
            end
            n_bin = i_mag;
        end else if (i_ctrl.step) begin
            n_bcd = {adj[DIGITS-1][2:0], adj[DIGITS-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_digit = r_bcd[i_idx];

endmodule

/* sv/integer_to_ascii_digits_unit.sv */
// Top level: sequencer and character output of the integer to ASCII digits unit.
//
// Usage: drive i_op and i_value and raise start while busy is low; the item
// is taken at that clock edge and busy rises on the next cycle.
// i_op selects signed decimal (two's complement, leading '-' when negative)
// or unsigned lower-case hexadecimal. Characters leave most significant
// first, one beat per cycle but for cycles that skip leading zeros, on
// o_char_code with o_valid high for exactly one cycle each; o_last marks
// the final character. Leading zeros are dropped, and zero gives a single '0'.
// Decimal: a load, then a shift-and-add-3 step for each of the VALUE_WIDTH
// bits in the shared digit unit, a '-' when negative, then a scan of the
// stored digits from the top of the 20-digit store, leading zeros skipped
// without a beat. Hexadecimal skips the shift loop and scans the lowest
// HEX_DIGITS digits of the store.
// busy drops in the cycle that shows the last character, so the next item
// may be taken then. The receiver cannot stall; every beat is final.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; the digit store is not cleared.
module integer_to_ascii_digits_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_op,
    input  logic [63:0]            i_value,
    output logic                   o_valid,
    output logic [6:0]             o_char_code,
    output logic                   o_last
);
    import itd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SCAN
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_neg, n_neg;
    logic                   r_seen, n_seen;
    logic                   r_valid, n_valid;
    logic [6:0]             r_char, n_char;
    logic                   r_last, n_last;

    logic [VALUE_WIDTH-1:0] val_w;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg_in;
    logic                   accept;
    t_dd_ctrl               dd_ctrl;
    logic [3:0]             digit;

    // magnitude of the incoming number
    assign val_w  = i_value[VALUE_WIDTH-1:0];
    assign neg_in = (i_op == OP_DEC) && val_w[VALUE_WIDTH-1];
    assign mag    = neg_in ? (~val_w + 1'b1) : val_w;
    assign accept = start && (r_state == S_IDLE);

    itd_dabble u_dabble (
        .i_clk   (i_clk),
        .i_ctrl  (dd_ctrl),
        .i_mag   (mag),
        .i_idx   (r_idx),
        .o_digit (digit)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_seen  = r_seen;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        dd_ctrl = '{load: accept, hex: (i_op == OP_HEX), step: (r_state == S_CONV)};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg  = neg_in;
                    n_seen = 1'b0;
                    n_cnt  = CNT_W'(VALUE_WIDTH - 1);
                    if (i_op == OP_HEX) begin
                        n_idx   = IDX_W'(HEX_DIGITS - 1);
                        n_state = S_SCAN;
                    end else begin
                        n_idx   = IDX_W'(DIGITS - 1);
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = r_neg ? S_SIGN : S_SCAN;
                end
            end
            S_SIGN: begin
                n_valid = 1'b1;
                n_char  = CH_MINUS;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!r_seen && digit == 4'd0 && r_idx != '0) begin
                    // leading zero: skip without a beat
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_seen  = 1'b1;
                    n_valid = 1'b1;
                    n_char  = digit_char(digit);
                    n_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
        r_char <= n_char;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

/* sv/itd_checker.sv */
// Port-level checks for the integer to ASCII digits unit, bound to the top level.
module itd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [6:0] o_char_code,
    input logic       o_last
);
    import itd_pkg::*;

    // a taken item keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("unit not busy after taking an item");

    // only legal characters leave the unit
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CH_MINUS)
                 || (o_char_code >= CH_ZERO && o_char_code <= CH_NINE)
                 || (o_char_code >= CH_LOWER_A && o_char_code <= CH_LOWER_F))
        else $error("illegal character code");

    // a sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CH_MINUS) |-> !o_last)
        else $error("minus sign flagged as last");

    // more characters follow, so the unit must still be busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("unit idle in the middle of a number");

    // nothing follows the last beat in the next cycle
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("beat right after the last character");

endmodule

bind integer_to_ascii_digits_unit itd_checker u_itd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

/* tb/itd_char_checker.sv */
// Checker for the integer to ASCII digits unit: predicts and compares every character beat.
module itd_char_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_op,
    input  logic [63:0] i_value,
    input  logic        i_valid,
    input  logic [6:0]  i_char_code,
    input  logic        i_last,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_chars_checked
);
    import itd_pkg::*;

    localparam logic [63:0] WIDTH_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_char_beat;

    t_char_beat expected_chars[$];
    t_char_beat want;
    int         fail_total = 0;
    int         checked_total = 0;

    // Expected characters of one number, most significant first
    function automatic void queue_characters(input logic op, input logic [63:0] raw);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [3:0]  digits [DIGITS];
        logic        neg;
        t_char_beat  beat;
        int          n;
        int          k;
        mag = raw & WIDTH_MASK;
        neg = (op == OP_DEC) && mag[VALUE_WIDTH-1];
        // magnitude of the most negative value fits as unsigned
        if (neg) begin
            mag = (~mag + 64'd1) & WIDTH_MASK;
        end
        radix = (op == OP_HEX) ? 64'd16 : 64'd10;
        n = 0;
        do begin
            if (n < DIGITS) begin
                digits[n] = 4'(mag % radix);
                n++;
            end
            mag = mag / radix;
        end while (mag != 64'd0);
        if (neg) begin
            beat.code = CH_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        for (k = n - 1; k >= 0; k--) begin
            if (digits[k] >= 4'd10) begin
                beat.code = CH_LOWER_A + 7'(digits[k] - 4'd10);
            end else begin
                beat.code = CH_ZERO + 7'(digits[k]);
            end
            beat.last = (k == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // Compare the output beat first, then queue the number taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid === 1'b1) begin
                if (expected_chars.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected beat, char 0x%02h last %0b, nothing expected",
                             $time, i_char_code, i_last);
                end else begin
                    want = expected_chars.pop_front();
                    checked_total++;
                    if (i_char_code !== want.code) begin
                        fail_total++;
                        $display("%0t: char_code mismatch, expected 0x%02h actual 0x%02h",
                                 $time, want.code, i_char_code);
                    end
                    if (i_last !== want.last) begin
                        fail_total++;
                        $display("%0t: last mismatch, expected %0b actual %0b",
                                 $time, want.last, i_last);
                    end
                end
            end
            if (i_start && i_busy === 1'b0) begin
                queue_characters(i_op, i_value);
            end
        end
        o_pending       <= expected_chars.size();
        o_fail_count    <= fail_total;
        o_chars_checked <= checked_total;
    end

endmodule

/* tb/tb_top.sv */
// Testbench top for the integer to ASCII digits unit: stimulus, watchdog and verdict.
module tb_top;
    import itd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 410;
    localparam int QUIET_TAIL     = 60;
    localparam int SETTLE_CYCLES  = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_op;
    logic [63:0] i_value;
    logic        o_valid;
    logic [6:0]  o_char_code;
    logic        o_last;

    int pending;
    int fail_count;
    int chars_checked;
    int idle_cycles = 0;
    int numbers_sent = 0;
    int hex_sent = 0;
    int negative_sent = 0;

    integer_to_ascii_digits_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    itd_char_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (i_op),
        .i_value         (i_value),
        .i_valid         (o_valid),
        .i_char_code     (o_char_code),
        .i_last          (o_last),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_chars_checked (chars_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: cycles with neither a number taken nor a character shown
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Hold start high until the unit takes the number
    task automatic send_number(input logic op, input logic [63:0] val);
        start   <= 1'b1;
        i_op    <= op;
        i_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        numbers_sent++;
        if (op == OP_HEX) begin
            hex_sent++;
        end else if (val[VALUE_WIDTH-1]) begin
            negative_sent++;
        end
    endtask

    // Sender gap of random length, start low, with junk on the data ports
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 16);
        start <= 1'b0;
        repeat (n) begin
            i_op    <= 1'($urandom);
            i_value <= {$urandom, $urandom};
            @(posedge i_clk);
        end
    endtask

    // Stop sending until every queued character has come out
    task automatic drain_outputs();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [63:0] val;
        logic [63:0] pow;
        logic        op;
        int          kind;
        int          i;
        int          j;

        start   <= 1'b0;
        i_op    <= OP_DEC;
        i_value <= 64'd0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, extremes, digit boundaries, both formats
        send_number(OP_DEC, 64'd0);
        send_number(OP_HEX, 64'd0);
        send_number(OP_DEC, 64'd1);
        send_number(OP_DEC, 64'd9);
        send_number(OP_DEC, 64'd10);
        send_number(OP_DEC, {64{1'b1}});
        send_number(OP_HEX, {64{1'b1}});
        send_number(OP_DEC, 64'h8000_0000_0000_0000);
        send_number(OP_HEX, 64'h8000_0000_0000_0000);
        send_number(OP_DEC, 64'h7fff_ffff_ffff_ffff);
        send_number(OP_HEX, 64'h7fff_ffff_ffff_ffff);
        drain_outputs();
        send_number(OP_HEX, 64'd9);
        send_number(OP_HEX, 64'd10);
        send_number(OP_HEX, 64'd15);
        send_number(OP_HEX, 64'd16);
        send_number(OP_HEX, 64'h0123_4567_89ab_cdef);
        send_number(OP_HEX, 64'hfedc_ba98_7654_3210);
        send_number(OP_DEC, 64'hffff_ffff_ffff_fff7);
        send_number(OP_DEC, 64'd1000000000000000000);
        send_number(OP_DEC, 64'd999999999999999999);
        send_number(OP_DEC, 64'h0123_4567_89ab_cdef);
        send_number(OP_DEC, 64'hfedc_ba98_7654_3210);

        // Random: mix of full-width, small, negative and boundary numbers
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            op   = 1'($urandom);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    val = {$urandom, $urandom};
                end
                3, 4: begin
                    val = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
                5, 6: begin
                    val = -({$urandom, $urandom} >> $urandom_range(1, 63));
                end
                7, 8: begin
                    pow = 64'd1;
                    if (op == OP_HEX) begin
                        pow = pow << (4 * $urandom_range(0, 15));
                    end else begin
                        for (j = $urandom_range(0, 19); j > 0; j--) begin
                            pow = pow * 64'd10;
                        end
                    end
                    val = pow + 64'($urandom_range(0, 2)) - 64'd1;
                    if ($urandom_range(0, 3) == 0) begin
                        val = -val;
                    end
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: val = 64'd0;
                        1: val = {64{1'b1}};
                        2: val = 64'h8000_0000_0000_0000;
                        default: val = 64'h7fff_ffff_ffff_ffff;
                    endcase
                end
            endcase
            send_number(op, val);
            if (i == RANDOM_ITEMS / 2) begin
                drain_outputs();
            end else if (i < RANDOM_ITEMS - QUIET_TAIL) begin
                // gaps land either during a conversion or across an item boundary
                case ($urandom_range(0, 5))
                    0: sender_gap();
                    1: begin
                        start <= 1'b0;
                        do @(posedge i_clk); while (busy !== 1'b0);
                        sender_gap();
                    end
                    default: ;
                endcase
            end
        end

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d numbers formatted, %0d in hex, %0d negative in decimal",
                 numbers_sent, hex_sent, negative_sent);
        $display("tb_top: %0d characters compared, %0d mismatches", chars_checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
